// ----- sv/relay_bank_runtime_meter_core_assert.svh -----
// Assertion macros for the relay bank runtime meter: same-cycle and next-cycle implications.
`ifndef RELAY_BANK_RUNTIME_METER_CORE_ASSERT_SVH
`define RELAY_BANK_RUNTIME_METER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/rbrm_pkg.sv -----
// Shared types and constants for the relay bank runtime meter.
package rbrm_pkg;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_TOGGLE  = 3'd1,
    OP_ALL_OFF = 3'd2,
    OP_ALL_ON  = 3'd3,
    OP_QUERY   = 3'd4,
    OP_UPDATE  = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GATE,
    S_ELAP,
    S_SEC,
    S_QUO,
    S_APPLY,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic walk_clr;
    logic walk_inc;
    logic ld_elap;
    logic ld_sec;
    logic ld_quo;
    logic apply;
    logic mark_update;
    logic ld_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    idx_valid;
    logic    upd_due;
    logic    walk_last;
  } ctl_stat_t;

  localparam logic [31:0] INTERVAL_RESET = 32'd10000;
  localparam logic [31:0] MS_PER_MIN     = 32'd60000;

  // x / 1000 == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
  localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;
  localparam int          DIV1000_SHIFT = 38;
  // x / 60 == (x * DIV60_MAGIC) >> DIV60_SHIFT for any 32-bit x
  localparam logic [31:0] DIV60_MAGIC   = 32'h88888889;
  localparam int          DIV60_SHIFT   = 37;

  // whole seconds in a 32-bit ms span, plus a remainder below 60
  localparam int          SEC_W    = 23;
  localparam int          QUO_W    = 17;
  localparam int          REM_W    = 6;
  localparam logic [SEC_W-1:0] SECS_MAX = 23'd4294967;

endpackage

// ----- sv/rbrm_in_if.sv -----
// Command channel: valid/ready plus one command beat.
interface rbrm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  relay_index;
  logic        on_value;
  logic [31:0] now_ms;

  modport source (output valid, opcode, relay_index, on_value, now_ms, input ready);
  modport sink   (input valid, opcode, relay_index, on_value, now_ms, output ready);
endinterface

// ----- sv/rbrm_out_if.sv -----
// Result channel: valid/ready plus one result beat.
interface rbrm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  relay_mask;
  logic [7:0]  pin_levels;
  logic [31:0] runtime_seconds;
  logic        relay_state;
  logic        index_error;

  modport source (output valid, relay_mask, pin_levels, runtime_seconds, relay_state,
                  index_error, input ready);
  modport sink   (input valid, relay_mask, pin_levels, runtime_seconds, relay_state,
                  index_error, output ready);
endinterface

// ----- sv/rbrm_datapath.sv -----
// Datapath: relay state and meters, ms-to-seconds and seconds-to-minutes dividers, result register.
`include "relay_bank_runtime_meter_core_assert.svh"
module rbrm_datapath
  import rbrm_pkg::*;
#(
  parameter int NUM_RELAYS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_relay_index,
  input  logic        in_on_value,
  input  logic [31:0] in_now_ms,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  output logic [7:0]  out_relay_mask,
  output logic [7:0]  out_pin_levels,
  output logic [31:0] out_runtime_seconds,
  output logic        out_relay_state,
  output logic        out_index_error
);

  localparam int IW = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_RELAYS - 1);

  // configuration and meter state
  logic [31:0]           interval_r;
  logic [31:0]           last_update_r;
  logic [NUM_RELAYS-1:0] relay_on_r;
  logic [31:0]           start_r   [NUM_RELAYS];
  logic [31:0]           minutes_r [NUM_RELAYS];
  logic [REM_W-1:0]      rem_r     [NUM_RELAYS];

  // captured command
  opcode_t     op_r;
  logic [7:0]  idx_r;
  logic        val_r;
  logic [31:0] now_r;

  // walk and arithmetic pipeline
  logic [IW-1:0]    walk_r;
  logic [31:0]      elap_r;
  logic [SEC_W-1:0] secs_r;
  logic [SEC_W-1:0] sum_r;
  logic [QUO_W-1:0] q_r;
  logic [31:0]      qsecs_r;

  logic             walking;
  logic             idx_valid;
  logic             single_op;
  logic [IW-1:0]    sel;
  logic             cur_on;
  logic             target;
  logic [63:0]      prod_ms;
  logic [SEC_W-1:0] sum_nxt;
  logic [63:0]      prod_sec;
  logic [SEC_W-1:0] q60;
  logic [SEC_W-1:0] fold_rem;
  logic [31:0]      q_ms;
  logic [31:0]      min60;
  logic [31:0]      total_secs;

  assign walking   = (op_r == OP_ALL_OFF) || (op_r == OP_ALL_ON) || (op_r == OP_UPDATE);
  assign single_op = (op_r == OP_SET) || (op_r == OP_TOGGLE) || (op_r == OP_QUERY);
  assign idx_valid = idx_r < 8'(NUM_RELAYS);
  assign sel       = walking ? walk_r : idx_r[IW-1:0];
  assign cur_on    = relay_on_r[sel];

  assign stat.op        = op_r;
  assign stat.idx_valid = idx_valid;
  assign stat.upd_due   = (now_r - last_update_r) >= interval_r;
  assign stat.walk_last = walk_r == LAST_IDX;

  always_comb begin
    unique case (op_r)
      OP_SET:     target = val_r;
      OP_TOGGLE:  target = ~cur_on;
      OP_ALL_ON:  target = 1'b1;
      OP_ALL_OFF: target = 1'b0;
      default:    target = cur_on;
    endcase
  end

  // ms -> whole seconds
  assign prod_ms  = {32'd0, elap_r} * {32'd0, DIV1000_MAGIC};
  // fold adds the old remainder; the update pass takes bare elapsed seconds
  assign sum_nxt  = (op_r == OP_UPDATE) ? secs_r : SEC_W'(rem_r[sel]) + secs_r;
  // seconds -> whole minutes
  assign prod_sec = {{(64-SEC_W){1'b0}}, sum_nxt} * {32'd0, DIV60_MAGIC};
  assign q60      = SEC_W'({q_r, 6'd0}) - SEC_W'({q_r, 2'd0});
  assign fold_rem = sum_r - q60;
  assign q_ms     = 32'(q_r) * MS_PER_MIN;
  assign min60    = {minutes_r[sel][25:0], 6'd0} - {minutes_r[sel][29:0], 2'd0};
  assign total_secs = min60 + 32'(rem_r[sel]) + (cur_on ? 32'(secs_r) : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= INTERVAL_RESET;
      last_update_r <= '0;
      relay_on_r    <= '0;
      walk_r        <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        start_r[i]   <= '0;
        minutes_r[i] <= '0;
        rem_r[i]     <= '0;
      end
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      if (cmd.mark_update) begin
        last_update_r <= now_r;
      end
      if (cmd.walk_clr) begin
        walk_r <= '0;
      end else if (cmd.walk_inc) begin
        walk_r <= walk_r + 1'b1;
      end
      if (cmd.apply) begin
        if (op_r == OP_UPDATE) begin
          if (cur_on && (q_r != '0)) begin
            minutes_r[sel] <= minutes_r[sel] + 32'(q_r);
            start_r[sel]   <= start_r[sel] + q_ms;
          end
        end else if (op_r != OP_QUERY && target != cur_on) begin
          relay_on_r[sel] <= target;
          if (target) begin
            start_r[sel] <= now_r;
          end else begin
            minutes_r[sel] <= minutes_r[sel] + 32'(q_r);
            rem_r[sel]     <= fold_rem[REM_W-1:0];
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode_t'(in_opcode);
      idx_r   <= in_relay_index;
      val_r   <= in_on_value;
      now_r   <= in_now_ms;
      qsecs_r <= '0;
    end else if (cmd.apply && op_r == OP_QUERY) begin
      qsecs_r <= total_secs;
    end
    if (cmd.ld_elap) begin
      elap_r <= now_r - start_r[sel];
    end
    if (cmd.ld_sec) begin
      secs_r <= prod_ms[DIV1000_SHIFT +: SEC_W];
    end
    if (cmd.ld_quo) begin
      sum_r <= sum_nxt;
      q_r   <= prod_sec[DIV60_SHIFT +: QUO_W];
    end
    if (cmd.ld_out) begin
      out_relay_mask      <= 8'(relay_on_r);
      out_pin_levels      <= ~8'(relay_on_r);
      out_runtime_seconds <= qsecs_r;
      out_relay_state     <= (single_op && idx_valid) ? relay_on_r[idx_r[IW-1:0]] : 1'b0;
      out_index_error     <= single_op && !idx_valid;
    end
  end

  `RBRM_ASSERT_NEXT(a_secs_range, clk, rst_n, cmd.ld_sec, secs_r <= SECS_MAX, "seconds out of range")
  `RBRM_ASSERT_NEXT(a_fold_rem, clk, rst_n, cmd.ld_quo, fold_rem < SEC_W'(60), "remainder not below 60")
  `RBRM_ASSERT_NEXT(a_walk_start, clk, rst_n, cmd.walk_clr, walk_r == '0, "walk did not restart")

endmodule

// ----- sv/rbrm_ctrl.sv -----
// Controller: command sequencing, relay walk and channel handshakes.
`include "relay_bank_runtime_meter_core_assert.svh"
module rbrm_ctrl
  import rbrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       walking;

  assign walking   = (stat.op == OP_ALL_OFF) || (stat.op == OP_ALL_ON) ||
                     (stat.op == OP_UPDATE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.walk_clr = 1'b1;
        unique case (stat.op)
          OP_SET, OP_TOGGLE, OP_QUERY: state_nxt = stat.idx_valid ? S_ELAP : S_DONE;
          OP_ALL_OFF, OP_ALL_ON:       state_nxt = S_ELAP;
          OP_UPDATE:                   state_nxt = S_GATE;
          default:                     state_nxt = S_DONE;
        endcase
      end
      S_GATE: begin
        if (stat.upd_due) begin
          cmd.mark_update = 1'b1;
          state_nxt       = S_ELAP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ELAP: begin
        cmd.ld_elap = 1'b1;
        state_nxt   = S_SEC;
      end
      S_SEC: begin
        cmd.ld_sec = 1'b1;
        state_nxt  = S_QUO;
      end
      S_QUO: begin
        cmd.ld_quo = 1'b1;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (walking && !stat.walk_last) begin
          cmd.walk_inc = 1'b1;
          state_nxt    = S_ELAP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `RBRM_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r == S_DECODE, "accepted beat not decoded")
  `RBRM_ASSERT_NEXT(a_single_once, clk, rst_n, state_r == S_APPLY && !walking, state_r == S_DONE, "single relay command applied twice")
  `RBRM_ASSERT_SAME(a_load_free, clk, rst_n, cmd.ld_out, !out_valid_r || out_ready, "result overwritten before taken")

endmodule

// ----- sv/relay_bank_runtime_meter_core.sv -----
// Relay bank runtime meter top level: controller, datapath and channel wiring.
// Set/toggle/query make one relay visit between accept and result valid (bad index or unused opcode:
//   none); all on/off visit every relay; periodic update visits every relay when due, else none.
// A new command is taken only after the last result is loaded; each relay visit runs through the shared
//   ms/1000 and sec/60 reciprocal multipliers in order (elapsed, seconds, minutes, write-back).
// Reset (rst_n low, sync): all relays off, meters and last-update time zero, interval 10000 ms.
module relay_bank_runtime_meter_core
  import rbrm_pkg::*;
#(
  parameter int NUM_RELAYS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rbrm_in_if.sink     in_if,
  rbrm_out_if.source  out_if
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer: accepts one command beat, walks relays when needed, then
  // parks the result in the output register. A new beat is taken as soon
  // as the result is loaded, even if the sink has not yet pulled it.
  rbrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Meter state, the divider pipeline and the result register.
  rbrm_datapath #(
    .NUM_RELAYS (NUM_RELAYS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_opcode           (in_if.opcode),
    .in_relay_index      (in_if.relay_index),
    .in_on_value         (in_if.on_value),
    .in_now_ms           (in_if.now_ms),
    .cmd                 (cmd),
    .stat                (stat),
    .out_relay_mask      (out_if.relay_mask),
    .out_pin_levels      (out_if.pin_levels),
    .out_runtime_seconds (out_if.runtime_seconds),
    .out_relay_state     (out_if.relay_state),
    .out_index_error     (out_if.index_error)
  );

endmodule
